>>> rtl/tccw_pkg.sv
// tccw_pkg: shared types and constants for the text console character writer.
// Used by tccw_front, tccw_back and text_console_char_writer.
package tccw_pkg;

  localparam int unsigned COLUMNS_DEF  = 80;
  localparam int unsigned ROWS_DEF     = 25;
  localparam int unsigned TAB_STEP_DEF = 4;

  localparam logic [7:0] CH_BLANK = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0a;

  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // OP_NOP: ignored character, scroll check still applies.
  // OP_SKIP: unknown request, touches nothing.
  typedef enum logic [2:0] {
    OP_NOP   = 3'd0,
    OP_PRINT = 3'd1,
    OP_BS    = 3'd2,
    OP_TAB   = 3'd3,
    OP_NL    = 3'd4,
    OP_CLEAR = 3'd5,
    OP_READ  = 3'd6,
    OP_SKIP  = 3'd7
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  code;
    logic [10:0] idx;
  } cmd_t;

endpackage

>>> rtl/text_console_char_writer.sv
// text_console_char_writer: top level of the text console character writer.
// Depends on tccw_pkg, tccw_front and tccw_back.
//
// Text console engine: a ROWS x COLUMNS character store plus cursor. Each
// request transaction (put, clear, read, or the unused code which changes
// nothing) yields one result transaction with the cursor and, for reads, the
// stored character. A front end classifies requests into a two-entry queue;
// a back end executes them against a store with one read and one write
// port. The back end takes a new request only once it has finished the
// last one and its result is not stalled. A scroll is done when a put finds
// the cursor below the bottom row, and a print from the parked end-of-row
// column may scroll once more. A stalled result holds the back end; the
// queue then fills and stall_o rises. After reset the store is filled with
// spaces before the first request is executed; requests queue meanwhile.
module text_console_char_writer #(
  parameter int unsigned COLUMNS  = tccw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS     = tccw_pkg::ROWS_DEF,
  parameter int unsigned TAB_STEP = tccw_pkg::TAB_STEP_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  char_code_i,
  input  logic [10:0] cell_index_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [4:0]  cursor_row_o,
  output logic [6:0]  cursor_col_o,
  output logic [10:0] cursor_position_o,
  output logic [7:0]  cell_char_o
);

  logic           cmd_valid, cmd_pop;
  tccw_pkg::cmd_t cmd;

  tccw_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .req_type_i, .char_code_i, .cell_index_i,
    .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop), .cmd_o(cmd)
  );

  tccw_back #(.COLUMNS(COLUMNS), .ROWS(ROWS), .TAB_STEP(TAB_STEP)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop), .cmd_i(cmd),
    .valid_o, .stall_i, .cursor_row_o, .cursor_col_o, .cursor_position_o,
    .cell_char_o
  );

endmodule

>>> rtl/tccw_front.sv
// tccw_front: accepts requests, classifies them and holds them in a short queue.
// Depends on tccw_pkg.
module tccw_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  logic [1:0]        req_type_i,
  input  logic [7:0]        char_code_i,
  input  logic [10:0]       cell_index_i,
  output logic              cmd_valid_o,
  input  logic              cmd_pop_i,
  output tccw_pkg::cmd_t    cmd_o
);

  tccw_pkg::cmd_t q_mem [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  tccw_pkg::op_e op;

  always_comb begin
    op = tccw_pkg::OP_NOP;
    case (req_type_i)
      tccw_pkg::REQ_PUT: begin
        if (char_code_i >= tccw_pkg::CH_BLANK && char_code_i <= tccw_pkg::CH_TILDE)
          op = tccw_pkg::OP_PRINT;
        else if (char_code_i == tccw_pkg::CH_BS) op = tccw_pkg::OP_BS;
        else if (char_code_i == tccw_pkg::CH_TAB) op = tccw_pkg::OP_TAB;
        else if (char_code_i == tccw_pkg::CH_NL) op = tccw_pkg::OP_NL;
        else op = tccw_pkg::OP_NOP;
      end
      tccw_pkg::REQ_CLEAR: op = tccw_pkg::OP_CLEAR;
      tccw_pkg::REQ_READ:  op = tccw_pkg::OP_READ;
      default:             op = tccw_pkg::OP_SKIP;
    endcase
  end

  assign stall_o     = (cnt_q == 2'd2);
  assign push        = valid_i && !stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rp_q];

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = cmd_pop_i ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wp_q] <= '{op: op, code: char_code_i, idx: cell_index_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_i |-> cmd_valid_o) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count overflow");
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !cmd_pop_i) |=> stall_o) else $error("full queue not stalled");
`endif

endmodule

>>> rtl/tccw_back.sv
// tccw_back: executes commands on the character store and the cursor.
// Depends on tccw_pkg.
module tccw_back #(
  parameter int unsigned COLUMNS  = tccw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS     = tccw_pkg::ROWS_DEF,
  parameter int unsigned TAB_STEP = tccw_pkg::TAB_STEP_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_pop_o,
  input  tccw_pkg::cmd_t    cmd_i,
  output logic              valid_o,
  input  logic              stall_i,
  output logic [4:0]        cursor_row_o,
  output logic [6:0]        cursor_col_o,
  output logic [10:0]       cursor_position_o,
  output logic [7:0]        cell_char_o
);

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_EXEC  = 6'b000010,
    ST_SCRR  = 6'b000100,
    ST_SCRW  = 6'b001000,
    ST_FILL  = 6'b010000,
    ST_READ  = 6'b100000
  } state_e;

  state_e st_q, st_d;
  logic [7:0]  mem [CELLS];
  logic [7:0]  rd_q;
  logic [AW-1:0] ra, wa, ptr_q, ptr_d;
  logic        re, we;
  logic [7:0]  wd;
  logic [4:0]  row_q, row_d;
  logic [6:0]  col_q, col_d;
  logic        ov_q, ov_d;
  logic [7:0]  cell_q, cell_d;
  logic        init_q, init_d;   // reset fill in progress: no result at its end
  tccw_pkg::cmd_t c_q, c_d;
  logic [AW-1:0] cur_addr;
  logic [11:0] pos;
  logic [7:0]  tcol;
  logic        busy;

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (re) rd_q <= mem[ra];
  end

  assign pos      = 12'(row_q) * 12'(COLUMNS) + 12'(col_q);
  assign cur_addr = AW'(pos);
  assign busy     = ov_q && stall_i;
  assign tcol     = 8'(col_q) + 8'(TAB_STEP);

  always_comb begin
    st_d = st_q; ptr_d = ptr_q; row_d = row_q; col_d = col_q;
    ov_d = ov_q && stall_i; cell_d = cell_q; c_d = c_q;
    init_d = init_q;
    re = 1'b0; ra = ptr_q; we = 1'b0; wa = ptr_q; wd = tccw_pkg::CH_BLANK;
    cmd_pop_o = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i && !busy) begin
          cmd_pop_o = 1'b1;
          c_d = cmd_i;
          cell_d = 8'd0;
          st_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (c_q.op == tccw_pkg::OP_CLEAR) begin
          ptr_d = '0; st_d = ST_FILL;
        end else if (c_q.op == tccw_pkg::OP_READ) begin
          if (32'(c_q.idx) < CELLS) begin
            re = 1'b1; ra = AW'(c_q.idx); st_d = ST_READ;
          end else begin
            ov_d = 1'b1; st_d = ST_IDLE;
          end
        end else if (c_q.op == tccw_pkg::OP_SKIP) begin
          ov_d = 1'b1; st_d = ST_IDLE;
        end else if (32'(row_q) >= ROWS) begin
          row_d = 5'(ROWS - 1); ptr_d = '0; re = 1'b1;
          ra = AW'(COLUMNS); st_d = ST_SCRR;
        end else if (c_q.op == tccw_pkg::OP_PRINT && 32'(col_q) >= COLUMNS) begin
          col_d = '0; row_d = row_q + 5'd1;
        end else begin
          ov_d = 1'b1; st_d = ST_IDLE;
          case (c_q.op)
            tccw_pkg::OP_PRINT: begin
              we = 1'b1; wa = cur_addr; wd = c_q.code;
              if (32'(col_q) + 1 >= COLUMNS) begin
                col_d = '0; row_d = row_q + 5'd1;
              end else col_d = col_q + 7'd1;
            end
            tccw_pkg::OP_BS: begin
              if (col_q != '0) begin
                col_d = col_q - 7'd1; we = 1'b1; wa = cur_addr - AW'(1);
              end else if (row_q != '0) begin
                col_d = 7'(COLUMNS); row_d = row_q - 5'd1;
              end
            end
            tccw_pkg::OP_TAB: begin
              if (32'(tcol) >= COLUMNS) begin
                col_d = '0; row_d = row_q + 5'd1;
              end else col_d = 7'(tcol);
            end
            tccw_pkg::OP_NL: begin
              col_d = '0; row_d = row_q + 5'd1;
            end
            default: ;
          endcase
        end
      end
      ST_SCRR: begin
        // rd_q holds cell ptr+COLUMNS; ST_SCRW writes it one row up, fetches next
        st_d = ST_SCRW;
      end
      ST_SCRW: begin
        we = 1'b1; wa = ptr_q;
        if (32'(ptr_q) < CELLS - COLUMNS) wd = rd_q;
        else wd = tccw_pkg::CH_BLANK;
        if (32'(ptr_q) == CELLS - 1) begin
          st_d = ST_EXEC;
        end else begin
          ptr_d = ptr_q + AW'(1);
          if (32'(ptr_q) + 1 < CELLS - COLUMNS) begin
            re = 1'b1; ra = AW'(32'(ptr_q) + 1 + COLUMNS); st_d = ST_SCRR;
          end
        end
      end
      ST_FILL: begin
        we = 1'b1; wa = ptr_q;
        if (32'(ptr_q) == CELLS - 1) begin
          row_d = '0; col_d = '0; ov_d = !init_q; init_d = 1'b0; st_d = ST_IDLE;
        end else ptr_d = ptr_q + AW'(1);
      end
      ST_READ: begin
        cell_d = rd_q; ov_d = 1'b1; st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_FILL; ptr_q <= '0; row_q <= '0; col_q <= '0;
      ov_q <= 1'b0; init_q <= 1'b1;
    end else begin
      st_q <= st_d; ptr_q <= ptr_d; row_q <= row_d; col_q <= col_d;
      ov_q <= ov_d; init_q <= init_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
    c_q    <= c_d;
  end

  assign valid_o           = ov_q;
  assign cursor_row_o      = row_q;
  assign cursor_col_o      = col_q;
  assign cursor_position_o = pos[10:0];
  assign cell_char_o       = cell_q;

`ifndef NO_ASSERTIONS
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (st_q == ST_IDLE && !busy)) else $error("pop while busy");
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(row_q) <= ROWS) else $error("cursor row out of range");
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) <= COLUMNS) else $error("cursor column out of range");
`endif

endmodule
